### sv/bd8_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the block delta8 / PCM16 audio decoder.
// No dependencies; the design files refer to this package by scoped names, the testbench imports it.
package bd8_pkg;

  // Frames per Delta8 block: one anchor word followed by delta bytes.
  localparam int BLOCK_FRAMES = 128;
  localparam int BLK_POS_W    = $clog2(BLOCK_FRAMES);

  // Field widths fixed by the stream format.
  localparam int FRAME_W   = 27;
  localparam int SAMPLE_W  = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Highest frame index; the frame counter stops here.
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENCODING_MODE = 2'd0,
    CFG_SAMPLE_COUNT  = 2'd1,
    CFG_FIRST_FRAME   = 2'd2,
    CFG_FRAME_COUNT   = 2'd3
  } cfg_reg_t;

  // Payload coding.
  typedef enum logic {
    MODE_PCM16  = 1'b0,
    MODE_DELTA8 = 1'b1
  } enc_mode_t;

  // One decoded frame, from the decoder to the window check.
  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] value;
    logic [FRAME_W-1:0]         index;
  } frame_info_t;

  // Window check result for the current frame.
  typedef struct packed {
    logic emit;
    logic last;
  } window_hit_t;

endpackage

### sv/bd8_decode.sv
`timescale 1ns / 1ps
// Byte-level decoder: PCM16 word pairing, Delta8 anchor and delta reconstruction,
// and the saturating frame counter. Depends on bd8_pkg.
module bd8_decode (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [bd8_pkg::BYTE_W-1:0]       data_byte,
  input  logic                             clip_start,
  input  bd8_pkg::enc_mode_t               mode,
  output bd8_pkg::frame_info_t             frame
);

  logic                                phase_r, phase_nxt, phase_c;
  logic [bd8_pkg::BYTE_W-1:0]          hold_r, hold_nxt;
  logic [bd8_pkg::BLK_POS_W-1:0]       pos_r, pos_nxt, pos_c;
  logic signed [bd8_pkg::SAMPLE_W-1:0] recon_r, recon_nxt;
  logic [bd8_pkg::FRAME_W-1:0]         idx_r, idx_nxt, idx_c;
  logic signed [bd8_pkg::SAMPLE_W-1:0] word;
  logic signed [bd8_pkg::SAMPLE_W+1:0] delta_ext, sum;
  logic signed [bd8_pkg::SAMPLE_W-1:0] clamped;
  logic                                done;
  logic signed [bd8_pkg::SAMPLE_W-1:0] value;

  // A clip start clears the counters before the byte is used.
  assign phase_c = clip_start ? 1'b0 : phase_r;
  assign pos_c   = clip_start ? '0 : pos_r;
  assign idx_c   = clip_start ? '0 : idx_r;

  // Little-endian word and the scaled, clamped delta sum.
  assign word      = {data_byte, hold_r};
  assign delta_ext = {{2{data_byte[bd8_pkg::BYTE_W-1]}}, data_byte, 8'h00};
  assign sum       = {{2{recon_r[bd8_pkg::SAMPLE_W-1]}}, recon_r} + delta_ext;

  always_comb begin
    if (sum[bd8_pkg::SAMPLE_W+1:bd8_pkg::SAMPLE_W-1] == 3'b000 ||
        sum[bd8_pkg::SAMPLE_W+1:bd8_pkg::SAMPLE_W-1] == 3'b111) begin
      clamped = sum[bd8_pkg::SAMPLE_W-1:0];
    end else if (sum[bd8_pkg::SAMPLE_W+1] == 1'b0) begin
      clamped = 16'sh7FFF;
    end else begin
      clamped = 16'sh8000;
    end
  end

  // Next state for one byte.
  always_comb begin
    phase_nxt = phase_c;
    pos_nxt   = pos_c;
    hold_nxt  = hold_r;
    recon_nxt = recon_r;
    done      = 1'b0;
    value     = word;
    if (mode == bd8_pkg::MODE_PCM16 || pos_c == '0) begin
      // PCM16 word or Delta8 block anchor.
      if (!phase_c) begin
        hold_nxt  = data_byte;
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        done      = 1'b1;
        if (mode == bd8_pkg::MODE_DELTA8) begin
          recon_nxt = word;
          pos_nxt   = bd8_pkg::BLK_POS_W'(1);
        end
      end
    end else begin
      // Delta byte; the block wraps back to an anchor after its last frame.
      recon_nxt = clamped;
      value     = clamped;
      done      = 1'b1;
      if (pos_c == bd8_pkg::BLK_POS_W'(bd8_pkg::BLOCK_FRAMES - 1)) begin
        pos_nxt   = '0;
        phase_nxt = 1'b0;
      end else begin
        pos_nxt = pos_c + bd8_pkg::BLK_POS_W'(1);
      end
    end
  end

  // Frame counter saturates at its top value.
  assign idx_nxt = (done && idx_c != bd8_pkg::FRAME_MAX) ?
                   idx_c + bd8_pkg::FRAME_W'(1) : idx_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      hold_r  <= '0;
      pos_r   <= '0;
      recon_r <= '0;
      idx_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      pos_r   <= pos_nxt;
      recon_r <= recon_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign frame.done  = done;
  assign frame.value = value;
  assign frame.index = idx_c;

endmodule

### sv/bd8_window.sv
`timescale 1ns / 1ps
// Output window check: decides whether a frame index is emitted and whether it
// is the last one requested. Depends on bd8_pkg.
module bd8_window (
  input  bd8_pkg::frame_info_t          frame,
  input  logic [bd8_pkg::FRAME_W-1:0]   sample_count,
  input  logic [bd8_pkg::FRAME_W-1:0]   first_frame,
  input  logic [bd8_pkg::FRAME_W-1:0]   frame_count,
  output bd8_pkg::window_hit_t          hit
);

  logic                        win_open;
  logic [bd8_pkg::FRAME_W-1:0] offset;

  // The window end is the nearer of first_frame + frame_count and sample_count,
  // so each bound is checked on its own and all compares run in parallel.
  assign win_open = (first_frame < sample_count) && (frame_count != '0);
  assign offset   = frame.index - first_frame;

  assign hit.emit = frame.done && win_open && (frame.index >= first_frame) &&
                    (offset < frame_count) && (frame.index < sample_count);
  assign hit.last = (offset == frame_count - bd8_pkg::FRAME_W'(1)) ||
                    (frame.index == sample_count - bd8_pkg::FRAME_W'(1));

endmodule

### sv/block_delta8_audio_decoder.sv
`timescale 1ns / 1ps
// Top level of the block delta8 / PCM16 audio decoder.
// Depends on bd8_pkg, bd8_decode and bd8_window.

// Bytes enter an input register and are decoded into an output register when
// that one is free or being drained, so one byte is taken every clock while the
// result side keeps up; a PCM16 frame needs two bytes, a Delta8 block an anchor
// word and one byte per later frame. The input register and the output register
// let a new byte in while a sample waits; a stalled output holds both once full.
// The user must write configuration only while no byte is in flight; the block
// does not enforce this. clip_start restarts frame and block counting.
module block_delta8_audio_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [bd8_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bd8_pkg::FRAME_W-1:0]       cfg_wdata,
  // Byte input.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bd8_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                              in_clip_start,
  // Sample output.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bd8_pkg::SAMPLE_W-1:0] out_sample,
  output logic                              out_final_frame
);

  bd8_pkg::enc_mode_t                  mode_r;
  logic [bd8_pkg::FRAME_W-1:0]         sample_count_r;
  logic [bd8_pkg::FRAME_W-1:0]         first_frame_r;
  logic [bd8_pkg::FRAME_W-1:0]         frame_count_r;

  logic                                s1_valid_r, s1_valid_nxt;
  logic [bd8_pkg::BYTE_W-1:0]          s1_byte_r;
  logic                                s1_start_r;
  logic                                step;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [bd8_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                out_final_r;

  bd8_pkg::frame_info_t                frame;
  bd8_pkg::window_hit_t                hit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= bd8_pkg::MODE_PCM16;
      sample_count_r <= bd8_pkg::FRAME_W'(1);
      first_frame_r  <= '0;
      frame_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (bd8_pkg::cfg_reg_t'(cfg_index))
        bd8_pkg::CFG_ENCODING_MODE: mode_r         <= bd8_pkg::enc_mode_t'(cfg_wdata[0]);
        bd8_pkg::CFG_SAMPLE_COUNT:  sample_count_r <= cfg_wdata;
        bd8_pkg::CFG_FIRST_FRAME:   first_frame_r  <= cfg_wdata;
        bd8_pkg::CFG_FRAME_COUNT:   frame_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The decode stage moves whenever the output register is free or being drained.
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_clip_start;
    end
  end

  bd8_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (s1_byte_r),
    .clip_start (s1_start_r),
    .mode       (mode_r),
    .frame      (frame)
  );

  bd8_window u_window (
    .frame        (frame),
    .sample_count (sample_count_r),
    .first_frame  (first_frame_r),
    .frame_count  (frame_count_r),
    .hit          (hit)
  );

  // Output register: loaded by a decoded frame inside the window.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = hit.emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hit.emit) begin
      out_sample_r <= frame.value;
      out_final_r  <= hit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_final_frame = out_final_r;

endmodule

### sv/bd8_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the block delta8 / PCM16 audio decoder, bound to the top.
// Depends on bd8_pkg and block_delta8_audio_decoder.
module bd8_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bd8_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_final_frame
);

  // A stalled sample holds its value until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) &&
                                $stable(out_final_frame))
    else $error("stalled sample changed");

  // Reset leaves no sample pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("sample pending after reset");

  // Input back-pressure only comes from a full, stalled output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  // A sample after an empty output comes from an earlier byte transfer that passed
  // through the input register and then into the output register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("sample without a preceding byte transfer");

endmodule

bind block_delta8_audio_decoder bd8_checker u_bd8_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_sample      (out_sample),
  .out_final_frame (out_final_frame)
);

### tb/block_delta8_audio_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_delta8_audio_decoder: PCM16 and Delta8 byte streams.
// Depends on bd8_pkg and the decoder RTL; a scoreboard class predicts each sample.

module block_delta8_audio_decoder_tb;
  import bd8_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int CYCLE_CAP  = 400000;
  localparam int ITEM_GOAL  = 1350;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE_CYC = 8;
  localparam int BURST_LEN  = 320;
  localparam logic [FRAME_W-1:0] CLIP_MAX_RANGE = 27'd100000000;

  // One expected sample at the output.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       final_frame;
  } sample_exp_t;

  // Predicts decoded samples from accepted bytes and checks the output against them.
  class sample_scoreboard;
    enc_mode_t                  mode;
    logic [FRAME_W-1:0]         n_samples;
    logic [FRAME_W-1:0]         win_first;
    logic [FRAME_W-1:0]         win_len;
    logic                       hi_phase;
    logic [BYTE_W-1:0]          low_hold;
    int unsigned                blk_pos;
    logic signed [SAMPLE_W-1:0] level;
    logic [FRAME_W-1:0]         frame_idx;
    sample_exp_t                pending_samples[$];
    int                         errors;

    function new();
      mode      = MODE_PCM16;
      n_samples = 1;
      win_first = 0;
      win_len   = 0;
      hi_phase  = 1'b0;
      low_hold  = '0;
      blk_pos   = 0;
      level     = '0;
      frame_idx = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [FRAME_W-1:0] val);
      case (idx)
        CFG_ENCODING_MODE: mode = enc_mode_t'(val[0]);
        CFG_SAMPLE_COUNT:  n_samples = val;
        CFG_FIRST_FRAME:   win_first = val;
        CFG_FRAME_COUNT:   win_len = val;
        default: ;
      endcase
    endfunction

    // Queue the frame if it falls in the requested window, then count it.
    function void emit_frame(logic signed [SAMPLE_W-1:0] v);
      longint unsigned f, ff, sc, avail, req, last;
      sample_exp_t e;
      f  = frame_idx;
      ff = win_first;
      sc = n_samples;
      if (ff < sc) begin
        avail = sc - ff;
        req   = (win_len < avail) ? win_len : avail;
        last  = ff + req;
        if (req != 0 && f >= ff && f < last) begin
          e.sample      = v;
          e.final_frame = (f + 1 == last);
          pending_samples.insert(pending_samples.size(), e);
        end
      end
      if (frame_idx != FRAME_MAX) frame_idx++;
    endfunction

    function void decode_byte(logic [BYTE_W-1:0] b, logic start);
      logic signed [SAMPLE_W-1:0] word;
      int sum;
      if (start) begin
        frame_idx = '0;
        hi_phase  = 1'b0;
        blk_pos   = 0;
      end
      if (mode == MODE_PCM16 || blk_pos == 0) begin
        // Little-endian word: a PCM16 frame or a block anchor.
        if (!hi_phase) begin
          low_hold = b;
          hi_phase = 1'b1;
        end else begin
          hi_phase = 1'b0;
          word = {b, low_hold};
          if (mode == MODE_DELTA8) begin
            level   = word;
            blk_pos = 1;
          end
          emit_frame(word);
        end
      end else begin
        // Signed delta byte scaled by 256, clamped to the sample range.
        sum = int'(level) + int'($signed(b)) * 256;
        if (sum > 32767) sum = 32767;
        else if (sum < -32768) sum = -32768;
        level = 16'(sum);
        blk_pos++;
        if (blk_pos >= BLOCK_FRAMES) begin
          blk_pos  = 0;
          hi_phase = 1'b0;
        end
        emit_frame(level);
      end
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] s, logic fin);
      sample_exp_t e;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample: sample actual %0d final_frame actual %0b", s, fin);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        if (s !== e.sample) begin
          $error("sample mismatch: expected %0d actual %0d", e.sample, s);
          errors++;
        end
        if (fin !== e.final_frame) begin
          $error("final_frame mismatch: expected %0b actual %0b", e.final_frame, fin);
          errors++;
        end
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [FRAME_W-1:0]         cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [BYTE_W-1:0]          in_data_byte = '0;
  logic                       in_clip_start = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_final_frame;

  sample_scoreboard sb = new();
  bit   no_idle  = 1'b0;
  bit   hold_req = 1'b0;
  int   n_sent   = 0;
  int   cycles   = 0;

  block_delta8_audio_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_clip_start  (in_clip_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_final_frame(out_final_frame)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: check each transfer, then pick out_ready for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_sample(out_sample, out_final_frame);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  // Offer one byte after zero or more idle cycles; returns at the transfer edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_clip_start <= start;
    do @(posedge clk); while (!in_ready);
    sb.decode_byte(b, start);
    n_sent++;
  endtask

  // Stop offering and wait until every expected sample is out and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [FRAME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(input enc_mode_t mode, input logic [FRAME_W-1:0] sc,
                          input logic [FRAME_W-1:0] ff, input logic [FRAME_W-1:0] fc);
    cfg_write(CFG_ENCODING_MODE, FRAME_W'(mode));
    cfg_write(CFG_SAMPLE_COUNT, sc);
    cfg_write(CFG_FIRST_FRAME, ff);
    cfg_write(CFG_FRAME_COUNT, fc);
    cfg_we <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    enc_mode_t          mode;
    logic [FRAME_W-1:0] sc, ff, fc;
    logic [BYTE_W-1:0]  data;
    int                 phase, clip_len;
    bit                 cont;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers give an empty window: bytes go in, nothing comes out.
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    wait_idle();

    // PCM16 window of two frames starting at frame 1, with frames outside on both ends.
    set_regs(MODE_PCM16, 27'd5, 27'd1, 27'd2);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    wait_idle();

    // Delta8 anchor at the top, clamp high, then large negative deltas down to the clamp.
    set_regs(MODE_DELTA8, CLIP_MAX_RANGE, 27'd0, 27'd5);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_idle();

    // Mode change in the middle of a clip: PCM16 continues from the current frame.
    set_regs(MODE_PCM16, CLIP_MAX_RANGE, 27'd0, 27'd100);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_idle();

    // Random clips, one register setting per phase.
    phase = 0;
    while (n_sent < ITEM_GOAL) begin
      mode = enc_mode_t'($urandom_range(1));
      case ($urandom_range(9))
        7:       sc = CLIP_MAX_RANGE;
        8:       sc = FRAME_MAX;
        9:       sc = 27'd1;
        default: sc = FRAME_W'($urandom_range(1, 400));
      endcase
      case ($urandom_range(9))
        7:       ff = sc;
        8:       ff = CLIP_MAX_RANGE;
        9:       ff = FRAME_MAX;
        default: ff = FRAME_W'($urandom_range(0, 40));
      endcase
      case ($urandom_range(9))
        0:       fc = 27'd0;
        1:       fc = CLIP_MAX_RANGE;
        2:       fc = FRAME_MAX;
        default: fc = FRAME_W'($urandom_range(1, 300));
      endcase
      if (phase == 1) begin
        sc = FRAME_MAX;
        ff = 27'd0;
        fc = FRAME_MAX;
      end else if (phase == 2) begin
        sc = CLIP_MAX_RANGE;
        ff = 27'd0;
        fc = CLIP_MAX_RANGE;
      end else if (phase == 3) begin
        sc = 27'd1;
        ff = 27'd0;
        fc = 27'd1;
      end
      set_regs(mode, sc, ff, fc);

      // A long output stall while bytes keep coming, and one phase with no idling.
      if (phase == 2) hold_req = 1'b1;
      no_idle = (phase == 4);
      cont = (phase == 5) || ($urandom_range(9) == 0);

      clip_len = no_idle ? BURST_LEN : $urandom_range(10, 320);
      for (int i = 0; i < clip_len; i++) begin
        if ($urandom_range(1)) data = 8'($urandom_range(255));
        else data = 8'($urandom_range(0, 16) - 8);
        send_byte(data, (i == 0 && !cont) || ($urandom_range(99) < 2));
      end
      wait_idle();
      phase++;
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk);
    if (sb.pending_samples.size() != 0) begin
      $error("%0d expected samples never arrived", sb.pending_samples.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/bd8_pkg.sv
sv/bd8_decode.sv
sv/bd8_window.sv
sv/block_delta8_audio_decoder.sv
sv/bd8_checker.sv
tb/block_delta8_audio_decoder_tb.sv
